/* rtl/bsc_pkg.sv */
// Shared types and constants for the barometric sensor compensation pipeline.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package bsc_pkg;

	localparam int unsigned DivBits = 64;
	localparam int unsigned DenW    = 31;

	localparam logic [20:0] PresFull   = 21'd1048576;
	localparam logic [24:0] FineOffset = 25'd128000;
	localparam logic [63:0] Bias47     = 64'h0000_8000_0000_0000;
	localparam logic [11:0] NumScale   = 12'd3125;

	typedef enum logic [1:0] {
		CFG_CAL_T    = 2'd0,
		CFG_CAL_P_LO = 2'd1,
		CFG_CAL_P_HI = 2'd2,
		CFG_CAL_P9   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} cal_t;

	typedef struct packed {
		logic [31:0] fine;
		logic [24:0] v1;
		logic [20:0] pbase;
	} temp_res_t;

	typedef struct packed {
		logic [31:0] fine;
		logic        neg;
		logic        zero;
	} side_t;

	typedef struct packed {
		logic [63:0]     num_mag;
		logic [DenW-1:0] den_mag;
		side_t           side;
	} div_in_t;

	typedef struct packed {
		logic [63:0] quot;
		side_t       side;
	} div_out_t;

	typedef struct packed {
		logic [31:0] fine;
		logic [31:0] pq;
		logic        fault;
	} result_t;

endpackage

`default_nettype wire

/* rtl/bsc_temp.sv */
// Temperature compensation stages: fine temperature and the offset term v1.
// Depends on bsc_pkg.
`default_nettype none

module bsc_temp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [19:0]        raw_t,
	input  logic [19:0]        raw_p,
	input  bsc_pkg::cal_t      cal,
	output logic               out_vld,
	output bsc_pkg::temp_res_t res
);
	import bsc_pkg::*;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [17:0] d1_s1, d1_c;
	logic signed [16:0] d2_s1, d2_c;
	logic [20:0]        pb_s1, pb_s2, pb_s3, pb_s4, pb_c;
	logic signed [33:0] m1_s2, sq_s2, m1_c, sq_c;
	logic signed [21:0] sqh_c;
	logic signed [22:0] tt1_s3;
	logic signed [37:0] a2_s3, a2_c;
	logic signed [23:0] a2h_c;
	logic signed [31:0] fine_s4, fine_c;
	logic signed [24:0] v1_s4, v1_c;

	assign d1_c   = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
	assign d2_c   = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, cal.t1});
	assign pb_c   = PresFull - {1'b0, raw_p};
	assign m1_c   = d1_s1 * $signed(cal.t2);
	assign sq_c   = d2_s1 * d2_s1;
	assign sqh_c  = sq_s2[33:12];
	assign a2_c   = sqh_c * $signed(cal.t3);
	assign a2h_c  = a2_s3[37:14];
	assign fine_c = {{9{tt1_s3[22]}}, tt1_s3} + {{8{a2h_c[23]}}, a2h_c};
	assign v1_c   = fine_c[24:0] - FineOffset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1   <= d1_c;
			d2_s1   <= d2_c;
			pb_s1   <= pb_c;
			m1_s2   <= m1_c;
			sq_s2   <= sq_c;
			pb_s2   <= pb_s1;
			tt1_s3  <= m1_s2[33:11];
			a2_s3   <= a2_c;
			pb_s3   <= pb_s2;
			fine_s4 <= fine_c;
			v1_s4   <= v1_c;
			pb_s4   <= pb_s3;
		end
	end

	assign out_vld   = vld_s4;
	assign res.fine  = fine_s4;
	assign res.v1    = v1_s4;
	assign res.pbase = pb_s4;

endmodule

`default_nettype wire

/* rtl/bsc_pcoef.sv */
// Pressure coefficient stages: builds the 64-bit wrapping dividend and the 31-bit
// divisor and hands their magnitudes and signs to the divider. Depends on bsc_pkg.
`default_nettype none

module bsc_pcoef (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  bsc_pkg::temp_res_t tin,
	input  bsc_pkg::cal_t      cal,
	output logic               out_vld,
	output bsc_pkg::div_in_t   dout
);
	import bsc_pkg::*;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [31:0]        fine_s1, fine_s2, fine_s3, fine_s4, fine_s5, fine_s6, fine_s7;
	logic [20:0]        pb_s1, pb_s2, pb_s3;
	logic signed [24:0] v1_c;
	logic signed [49:0] v1sq_s1, v1sq_c;
	logic signed [40:0] v1p5_s1, v1p5_s2, v1p5_c;
	logic signed [40:0] v1p2_s1, v1p2_s2, v1p2_c;
	logic signed [65:0] x6_c, x3_c;
	logic [63:0]        x6_s2;
	logic signed [63:0] x3_s2, x3sh_c;
	logic [63:0]        v2_s3, a_s3, v2_c, a_c;
	logic [47:0]        dl_s4;
	logic [31:0]        dh_s4;
	logic [63:0]        num0_s4, num0_c;
	logic [63:0]        dsum_c;
	logic [DenW-1:0]    den_s5, den_s6;
	logic [43:0]        nl_s5;
	logic [31:0]        nh_s5;
	logic [63:0]        num_s6;
	logic [63:0]        nmag_s7;
	logic [DenW-1:0]    dmag_s7;
	logic               neg_s7, zero_s7;

	assign v1_c   = tin.v1;
	assign v1sq_c = v1_c * v1_c;
	assign v1p5_c = v1_c * $signed(cal.p5);
	assign v1p2_c = v1_c * $signed(cal.p2);
	assign x6_c   = v1sq_s1 * $signed(cal.p6);
	assign x3_c   = v1sq_s1 * $signed(cal.p3);
	assign x3sh_c = x3_s2 >>> 8;
	assign v2_c   = x6_s2
		+ ({{23{v1p5_s2[40]}}, v1p5_s2} << 17)
		+ ({{48{cal.p4[15]}}, cal.p4} << 35);
	assign a_c    = x3sh_c + ({{23{v1p2_s2[40]}}, v1p2_s2} << 12) + Bias47;
	assign num0_c = ({43'd0, pb_s3} << 31) - v2_s3;
	assign dsum_c = {16'd0, dl_s4} + {dh_s4, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fine_s1 <= tin.fine;
			pb_s1   <= tin.pbase;
			v1sq_s1 <= v1sq_c;
			v1p5_s1 <= v1p5_c;
			v1p2_s1 <= v1p2_c;

			fine_s2 <= fine_s1;
			pb_s2   <= pb_s1;
			x6_s2   <= x6_c[63:0];
			x3_s2   <= x3_c[63:0];
			v1p5_s2 <= v1p5_s1;
			v1p2_s2 <= v1p2_s1;

			fine_s3 <= fine_s2;
			pb_s3   <= pb_s2;
			v2_s3   <= v2_c;
			a_s3    <= a_c;

			fine_s4 <= fine_s3;
			dl_s4   <= a_s3[31:0] * cal.p1;
			dh_s4   <= 32'(a_s3[63:32] * {16'd0, cal.p1});
			num0_s4 <= num0_c;

			fine_s5 <= fine_s4;
			den_s5  <= dsum_c[63:33];
			nl_s5   <= num0_s4[31:0] * NumScale;
			nh_s5   <= 32'(num0_s4[63:32] * {20'd0, NumScale});

			fine_s6 <= fine_s5;
			den_s6  <= den_s5;
			num_s6  <= {20'd0, nl_s5} + {nh_s5, 32'd0};

			fine_s7 <= fine_s6;
			neg_s7  <= num_s6[63] ^ den_s6[DenW-1];
			zero_s7 <= (den_s6 == '0);
			nmag_s7 <= num_s6[63] ? (64'd0 - num_s6) : num_s6;
			dmag_s7 <= den_s6[DenW-1] ? ('0 - den_s6) : den_s6;
		end
	end

	assign out_vld        = vld_s7;
	assign dout.num_mag   = nmag_s7;
	assign dout.den_mag   = dmag_s7;
	assign dout.side.fine = fine_s7;
	assign dout.side.neg  = neg_s7;
	assign dout.side.zero = zero_s7;

endmodule

`default_nettype wire

/* rtl/bsc_div.sv */
// Pipelined restoring divider: one quotient bit per stage over 64 stages.
// Unsigned magnitudes in, unsigned quotient out. Depends on bsc_pkg.
`default_nettype none

module bsc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  bsc_pkg::div_in_t  din,
	output logic              out_vld,
	output bsc_pkg::div_out_t dout
);
	import bsc_pkg::*;

	logic            vld_s  [1:DivBits];
	logic [DenW-1:0] rem_s  [1:DivBits];
	logic [63:0]     nq_s   [1:DivBits];
	logic [DenW-1:0] dmag_s [1:DivBits];
	side_t           side_s [1:DivBits];

	for (genvar k = 0; k < DivBits; k++) begin : g_stage
		logic            vld_cur;
		logic [DenW-1:0] rem_cur;
		logic [63:0]     nq_cur;
		logic [DenW-1:0] dmag_cur;
		side_t           side_cur;
		logic [DenW:0]   cand;
		logic [DenW+1:0] diff;
		logic            qbit;

		if (k == 0) begin : g_src
			assign vld_cur  = in_vld;
			assign rem_cur  = '0;
			assign nq_cur   = din.num_mag;
			assign dmag_cur = din.den_mag;
			assign side_cur = din.side;
		end else begin : g_mid
			assign vld_cur  = vld_s[k];
			assign rem_cur  = rem_s[k];
			assign nq_cur   = nq_s[k];
			assign dmag_cur = dmag_s[k];
			assign side_cur = side_s[k];
		end

		assign cand = {rem_cur, nq_cur[63]};
		assign diff = {1'b0, cand} - {2'b00, dmag_cur};
		assign qbit = !diff[DenW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= qbit ? diff[DenW-1:0] : cand[DenW-1:0];
				nq_s[k+1]   <= {nq_cur[62:0], qbit};
				dmag_s[k+1] <= dmag_cur;
				side_s[k+1] <= side_cur;
			end
		end
	end

	assign out_vld   = vld_s[DivBits];
	assign dout.quot = nq_s[DivBits];
	assign dout.side = side_s[DivBits];

endmodule

`default_nettype wire

/* rtl/bsc_post.sv */
// Post-division stages: sign fix, the P7..P9 correction terms and saturation
// to unsigned Q24.8. Depends on bsc_pkg.
`default_nettype none

module bsc_post (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  bsc_pkg::div_out_t din,
	input  bsc_pkg::cal_t     cal,
	output logic              out_vld,
	output bsc_pkg::result_t  res
);
	import bsc_pkg::*;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [63:0]        p_s1, p_s2, p_s3, p_s4, p_s5;
	logic signed [63:0] psig_c, s_c;
	logic [63:0]        ssl_s2;
	logic [31:0]        ssx_s2;
	logic signed [48:0] m8l_s2, m8l_c;
	logic [31:0]        m8h_s2;
	logic [63:0]        sq_s3;
	logic signed [63:0] w2full_c, w2_s3, w2_s4, w2_s5;
	logic signed [48:0] m9l_s4, m9l_c;
	logic [31:0]        m9h_s4;
	logic signed [63:0] w1full_c, w1_s5;
	logic [63:0]        tot_s6;
	logic signed [63:0] totsig_c, totsh_c;
	logic [63:0]        r_s7;
	logic [31:0]        p8_w, p9_w;

	assign p8_w     = {{16{cal.p8[15]}}, cal.p8};
	assign p9_w     = {{16{cal.p9[15]}}, cal.p9};
	assign psig_c   = p_s1;
	assign s_c      = psig_c >>> 13;
	assign m8l_c    = $signed({1'b0, p_s1[31:0]}) * $signed(cal.p8);
	assign w2full_c = {{15{m8l_s2[48]}}, m8l_s2} + {m8h_s2, 32'd0};
	assign m9l_c    = $signed({1'b0, sq_s3[31:0]}) * $signed(cal.p9);
	assign w1full_c = {{15{m9l_s4[48]}}, m9l_s4} + {m9h_s4, 32'd0};
	assign totsig_c = tot_s6;
	assign totsh_c  = totsig_c >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= din.side;
			p_s1    <= din.side.neg ? (64'd0 - din.quot) : din.quot;

			side_s2 <= side_s1;
			p_s2    <= p_s1;
			ssl_s2  <= s_c[31:0] * s_c[31:0];
			ssx_s2  <= 32'(s_c[31:0] * s_c[63:32]);
			m8l_s2  <= m8l_c;
			m8h_s2  <= 32'(p_s1[63:32] * p8_w);

			side_s3 <= side_s2;
			p_s3    <= p_s2;
			sq_s3   <= ssl_s2 + {ssx_s2[30:0], 33'd0};
			w2_s3   <= w2full_c >>> 19;

			side_s4 <= side_s3;
			p_s4    <= p_s3;
			w2_s4   <= w2_s3;
			m9l_s4  <= m9l_c;
			m9h_s4  <= 32'(sq_s3[63:32] * p9_w);

			side_s5 <= side_s4;
			p_s5    <= p_s4;
			w2_s5   <= w2_s4;
			w1_s5   <= w1full_c >>> 25;

			side_s6 <= side_s5;
			tot_s6  <= p_s5 + w1_s5 + w2_s5;

			side_s7 <= side_s6;
			r_s7    <= totsh_c + ({{48{cal.p7[15]}}, cal.p7} << 4);
		end
	end

	always_comb begin
		res.fine  = side_s7.fine;
		res.fault = side_s7.zero;
		if (side_s7.zero || r_s7[63]) begin
			res.pq = '0;
		end else if (r_s7[62:32] != '0) begin
			res.pq = '1;
		end else begin
			res.pq = r_s7[31:0];
		end
	end

	assign out_vld = vld_s7;

endmodule

`default_nettype wire

/* rtl/baro_sensor_compensation.sv */
// Barometric sensor compensation, top level: calibration registers, pipeline, output skid.
// One sample beat per cycle is accepted, except while the output skid register is full.
// The 64 one-bit divider stages set the depth; all stages advance together and hold
// only while the output skid register is full. Reset clears calibration and all valid bits.
// Depends on bsc_pkg, bsc_temp, bsc_pcoef, bsc_div and bsc_post.
`default_nettype none

module baro_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] fine_temperature,
	output logic [31:0] pressure_q24_8,
	output logic        divide_fault,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import bsc_pkg::*;

	logic [47:0] cal_t_q;
	logic [63:0] cal_plo_q;
	logic [63:0] cal_phi_q;
	logic [15:0] cal_p9_q;
	cal_t        cal;

	logic        en;
	logic        temp_vld, coef_vld, div_vld, post_vld_raw, post_vld;
	temp_res_t   temp_res;
	div_in_t     div_in;
	div_out_t    div_out;
	result_t     post_res;
	logic        out_vld_q, skid_vld_q;
	result_t     out_q, skid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t_q   <= '0;
			cal_plo_q <= '0;
			cal_phi_q <= '0;
			cal_p9_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CAL_T:    cal_t_q   <= cfg_data[47:0];
				CFG_CAL_P_LO: cal_plo_q <= cfg_data;
				CFG_CAL_P_HI: cal_phi_q <= cfg_data;
				CFG_CAL_P9:   cal_p9_q  <= cfg_data[15:0];
			endcase
		end
	end

	assign cal.t1 = cal_t_q[15:0];
	assign cal.t2 = cal_t_q[31:16];
	assign cal.t3 = cal_t_q[47:32];
	assign cal.p1 = cal_plo_q[15:0];
	assign cal.p2 = cal_plo_q[31:16];
	assign cal.p3 = cal_plo_q[47:32];
	assign cal.p4 = cal_plo_q[63:48];
	assign cal.p5 = cal_phi_q[15:0];
	assign cal.p6 = cal_phi_q[31:16];
	assign cal.p7 = cal_phi_q[47:32];
	assign cal.p8 = cal_phi_q[63:48];
	assign cal.p9 = cal_p9_q;

	assign en           = !skid_vld_q;
	assign sample_ready = en;

	bsc_temp u_temp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sample_valid),
		.raw_t   (raw_temperature),
		.raw_p   (raw_pressure),
		.cal     (cal),
		.out_vld (temp_vld),
		.res     (temp_res)
	);

	bsc_pcoef u_pcoef (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (temp_vld),
		.tin     (temp_res),
		.cal     (cal),
		.out_vld (coef_vld),
		.dout    (div_in)
	);

	bsc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (coef_vld),
		.din     (div_in),
		.out_vld (div_vld),
		.dout    (div_out)
	);

	bsc_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (div_vld),
		.din     (div_out),
		.cal     (cal),
		.out_vld (post_vld_raw),
		.res     (post_res)
	);

	assign post_vld = post_vld_raw && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (result_ready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= post_vld;
			end
		end else if (post_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (result_ready || !out_vld_q) begin
			out_q <= skid_vld_q ? skid_q : post_res;
		end else if (post_vld) begin
			skid_q <= post_res;
		end
	end

	assign result_valid     = out_vld_q;
	assign fine_temperature = out_q.fine;
	assign pressure_q24_8   = out_q.pq;
	assign divide_fault     = out_q.fault;

endmodule

`default_nettype wire
